[rtl/core/cpd_pkg.sv]
// Shared types and constants of the checked packet deframer.
package cpd_pkg;

    // Reset values of the configuration registers.
    localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] CHECKSUM_SEED_RESET = 16'd8217;
    localparam logic [7:0]  HEAD_CODE_A_RESET   = 8'hBB;
    localparam logic [7:0]  HEAD_CODE_B_RESET   = 8'hCC;

    // Configuration register indexes (byte address divided by four).
    localparam int unsigned REG_COUNT  = 4;
    localparam int unsigned REG_IDX_W  = $clog2(REG_COUNT);
    localparam int unsigned PADDR_W    = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IDLE_TIMEOUT  = 2'd0,
        REG_CHECKSUM_SEED = 2'd1,
        REG_HEAD_CODE_A   = 2'd2,
        REG_HEAD_CODE_B   = 2'd3
    } t_reg_idx;

    // Request opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Role that a received byte played in a frame.
    typedef enum logic [2:0] {
        ROLE_NONE = 3'd0,
        ROLE_HEAD = 3'd1,
        ROLE_LEN  = 3'd2,
        ROLE_PAY  = 3'd3,
        ROLE_CKH  = 3'd4,
        ROLE_CKL  = 3'd5
    } t_role;

    typedef struct packed {
        logic [15:0] idle_timeout_ticks;
        logic [15:0] checksum_seed;
        logic [7:0]  head_code_a;
        logic [7:0]  head_code_b;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        t_role      byte_role;
        logic       frame_done;
        logic       frame_ok;
        logic       head_error;
        logic       timed_out;
    } t_result;

endpackage

[rtl/core/cpd_parser.sv]
// Frame parser: frame state, checksum sum, idle timer and the result register.
module cpd_parser import cpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_PAY,
        PH_CKH,
        PH_CKL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_running_sum, n_running_sum;
    logic [7:0]  r_checksum_high, n_checksum_high;
    logic [15:0] r_idle_count, n_idle_count;
    logic        r_jammed, n_jammed;
    t_result     r_res, n_res;

    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_running_sum   = r_running_sum;
        n_checksum_high = r_checksum_high;
        n_idle_count    = r_idle_count;
        n_jammed        = r_jammed;
        n_res           = '0;
        n_res.byte_role = ROLE_NONE;

        if (i_opcode == OP_BYTE) begin
            // Any byte restarts the idle timer, even one that is discarded.
            n_idle_count    = '0;
            n_res.data_byte = i_rx_byte;
            if (!r_jammed) begin
                case (r_phase)
                    PH_IDLE: begin
                        if (i_rx_byte == i_cfg.head_code_a ||
                            i_rx_byte == i_cfg.head_code_b) begin
                            n_running_sum   = i_cfg.checksum_seed + {8'd0, i_rx_byte};
                            n_phase         = PH_LEN;
                            n_res.byte_role = ROLE_HEAD;
                        end else begin
                            n_jammed         = 1'b1;
                            n_res.head_error = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        n_bytes_left    = i_rx_byte;
                        n_running_sum   = r_running_sum + {8'd0, i_rx_byte};
                        n_phase         = (i_rx_byte == 8'd0) ? PH_CKH : PH_PAY;
                        n_res.byte_role = ROLE_LEN;
                    end
                    PH_PAY: begin
                        n_running_sum   = r_running_sum + {8'd0, i_rx_byte};
                        n_bytes_left    = r_bytes_left - 8'd1;
                        if (r_bytes_left == 8'd1) begin
                            n_phase = PH_CKH;
                        end
                        n_res.byte_role = ROLE_PAY;
                    end
                    PH_CKH: begin
                        n_checksum_high = i_rx_byte;
                        n_phase         = PH_CKL;
                        n_res.byte_role = ROLE_CKH;
                    end
                    PH_CKL: begin
                        n_res.byte_role  = ROLE_CKL;
                        n_res.frame_done = 1'b1;
                        n_res.frame_ok   = ({r_checksum_high, i_rx_byte} == r_running_sum);
                        n_phase          = PH_IDLE;
                        n_bytes_left     = '0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else begin
            // Saturating tick count, then the timeout compare on the new count.
            n_idle_count = (r_idle_count == '1) ? r_idle_count : r_idle_count + 16'd1;
            if ((r_phase != PH_IDLE || r_jammed) &&
                n_idle_count >= i_cfg.idle_timeout_ticks) begin
                n_phase         = PH_IDLE;
                n_bytes_left    = '0;
                n_jammed        = 1'b0;
                n_res.timed_out = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bytes_left  <= '0;
            r_idle_count  <= '0;
            r_jammed      <= 1'b0;
            r_running_sum <= CHECKSUM_SEED_RESET;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_bytes_left    <= n_bytes_left;
            r_running_sum   <= n_running_sum;
            r_checksum_high <= n_checksum_high;
            r_idle_count    <= n_idle_count;
            r_jammed        <= n_jammed;
            r_res           <= n_res;
        end
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_byte_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == OP_BYTE |=> r_idle_count == 16'd0)
        else $error("idle count not cleared by a received byte");

    a_jammed_discards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == OP_BYTE && r_jammed |=>
            r_res.byte_role == ROLE_NONE && r_jammed && !r_res.head_error)
        else $error("byte while jammed was not discarded");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == OP_TICK && r_phase == PH_IDLE && !r_jammed |=>
            !r_res.timed_out && r_res.byte_role == ROLE_NONE)
        else $error("tick with nothing pending raised a flag");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> !r_res.timed_out || (r_phase == PH_IDLE && !r_jammed))
        else $error("timeout left a partial frame or jam behind");
`endif

endmodule

[rtl/core/checked_packet_deframer_top.sv]
// Top level of the checked packet deframer: register port, handshakes and parser.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ----------------------------------------
//   in       to block   i_in_valid / o_in_stall   i_opcode, i_rx_byte
//   out      from block o_out_valid / i_out_stall o_data_byte, o_byte_role, o_frame_done,
//                                                 o_frame_ok, o_head_error, o_timed_out
//   config   to block   psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// Every request yields exactly one result, in the cycle after it is accepted.
// One request is taken per clock while the output is not stalled; the frame state
// update (the compares, one 16-bit add and the idle counter compare) is combinational.
// Reset (i_rst_n low at a clock edge) returns the frame state to idle, clears
// the jam, the idle count and the result valid flag, and reloads the registers.
// The input is stalled only while a result is held and the output is stalled;
// a result that is being taken frees the register for the next request at once.
module checked_packet_deframer_top import cpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_rx_byte,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_data_byte,
    output logic [2:0]         o_byte_role,
    output logic               o_frame_done,
    output logic               o_frame_ok,
    output logic               o_head_error,
    output logic               o_timed_out,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers. Writes are expected only while the block is
    // idle, so the parser reads them directly with no shadow copies.
    logic [15:0] r_idle_timeout_ticks;
    logic [15:0] r_checksum_seed;
    logic [7:0]  r_head_code_a;
    logic [7:0]  r_head_code_b;

    logic        cfg_write;
    t_reg_idx    reg_idx;
    t_cfg        cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout_ticks <= IDLE_TIMEOUT_RESET;
            r_checksum_seed      <= CHECKSUM_SEED_RESET;
            r_head_code_a        <= HEAD_CODE_A_RESET;
            r_head_code_b        <= HEAD_CODE_B_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_IDLE_TIMEOUT:  r_idle_timeout_ticks <= pwdata[15:0];
                REG_CHECKSUM_SEED: r_checksum_seed      <= pwdata[15:0];
                REG_HEAD_CODE_A:   r_head_code_a        <= pwdata[7:0];
                REG_HEAD_CODE_B:   r_head_code_b        <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back is combinational; the register value is zero-extended.
    always_comb begin
        case (reg_idx)
            REG_IDLE_TIMEOUT:  prdata = {16'd0, r_idle_timeout_ticks};
            REG_CHECKSUM_SEED: prdata = {16'd0, r_checksum_seed};
            REG_HEAD_CODE_A:   prdata = {24'd0, r_head_code_a};
            REG_HEAD_CODE_B:   prdata = {24'd0, r_head_code_b};
            default:           prdata = '0;
        endcase
    end

    assign cfg.idle_timeout_ticks = r_idle_timeout_ticks;
    assign cfg.checksum_seed      = r_checksum_seed;
    assign cfg.head_code_a        = r_head_code_a;
    assign cfg.head_code_b        = r_head_code_b;

    // Handshake. The result register is free when it is empty or when its
    // result is taken in this same cycle, so requests flow back to back.
    logic    r_out_valid;
    logic    in_accept;
    logic    out_taken;
    t_result res;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_taken  = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    // The parser updates the frame state and loads its result register on
    // each accepted request; the result then holds until the next one.
    cpd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_opcode  (i_opcode),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = res.data_byte;
    assign o_byte_role  = res.byte_role;
    assign o_frame_done = res.frame_done;
    assign o_frame_ok   = res.frame_ok;
    assign o_head_error = res.head_error;
    assign o_timed_out  = res.timed_out;

endmodule
